// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers clocked on i_clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pmvw_pkg.sv -----
// ----------------------------------------------------------------------------
// pmvw_pkg
// shared types, constants and binning function for the popular vector window
// ----------------------------------------------------------------------------
package pmvw_pkg;

    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int FRAC_BITS  = 4;
    localparam int HIST_BINS  = 65;
    localparam int RADIUS_MAX = 3;
    localparam int PIX_MAX    = 64;

    localparam int COL_W   = 6;
    localparam int ROW_W   = 6;
    localparam int VEC_W   = 16;
    localparam int OUT_W   = 8;
    localparam int CFGD_W  = 7;
    localparam int RAD_W   = 2;
    localparam int CIDX_W  = 2;

    localparam int DIM_W   = $clog2(((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS) + 1);
    localparam int ADDR_W  = $clog2(MAX_COLS * MAX_ROWS);
    localparam int BIN_W   = $clog2(HIST_BINS);
    localparam int WIN_MAX = (2 * RADIUS_MAX + 1) * (2 * RADIUS_MAX + 1);
    localparam int HCNT_W  = $clog2(WIN_MAX + 1);
    localparam int OFS_W   = $clog2(RADIUS_MAX + 1) + 1;
    localparam int HALF    = (FRAC_BITS == 0) ? 0 : (1 << (FRAC_BITS - 1));
    localparam int PEAK_MIN = 2;

    localparam int QDEPTH  = 2;
    localparam int QP_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W    = $clog2(QDEPTH + 1);

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_GRID_COLS     = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_GRID_ROWS     = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_WINDOW_RADIUS = 2'd2;

    // item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                    action;
        logic [COL_W-1:0]        col;
        logic [ROW_W-1:0]        row;
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef struct packed {
        logic [DIM_W-1:0] cols;
        logic [DIM_W-1:0] rows;
        logic [RAD_W-1:0] radius;
    } t_cfg;

    // round half away from zero, clamp to +-64, map to bin (v + 64) >> 1
    function automatic logic [BIN_W-1:0] to_bin(input logic signed [VEC_W-1:0] v);
        logic [VEC_W:0] mag;
        logic [VEC_W:0] pix;
        logic [BIN_W:0] t;
        mag = v[VEC_W-1] ? (~{v[VEC_W-1], v} + 1'b1) : {1'b0, v};
        pix = (mag + (VEC_W + 1)'(HALF)) >> FRAC_BITS;
        if (pix > (VEC_W + 1)'(PIX_MAX)) begin
            pix = (VEC_W + 1)'(PIX_MAX);
        end
        if (v[VEC_W-1]) begin
            t = (BIN_W + 1)'(PIX_MAX) - pix[BIN_W:0];
        end else begin
            t = (BIN_W + 1)'(PIX_MAX) + pix[BIN_W:0];
        end
        return t[BIN_W:1];
    endfunction

endpackage

// ----- design/pmvw_ifs.sv -----
// ----------------------------------------------------------------------------
// pmvw_ifs
// valid/ready channels for request items and results
// ----------------------------------------------------------------------------
interface pmvw_in_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [pmvw_pkg::COL_W-1:0]      col;
    logic [pmvw_pkg::ROW_W-1:0]      row;
    logic signed [pmvw_pkg::VEC_W-1:0] vec_x;
    logic signed [pmvw_pkg::VEC_W-1:0] vec_y;

    modport source (output valid, action, col, row, vec_x, vec_y, input ready);
    modport sink   (input valid, action, col, row, vec_x, vec_y, output ready);
endinterface

interface pmvw_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [pmvw_pkg::OUT_W-1:0] popular_x;
    logic signed [pmvw_pkg::OUT_W-1:0] popular_y;
    logic                              found;

    modport source (output valid, popular_x, popular_y, found, input ready);
    modport sink   (input valid, popular_x, popular_y, found, output ready);
endinterface

// ----- design/pmvw_cfg.sv -----
// ----------------------------------------------------------------------------
// pmvw_cfg
// configuration registers with grid size limited to the store
// ----------------------------------------------------------------------------
module pmvw_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pmvw_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [pmvw_pkg::CFGD_W-1:0]   i_cfg_data,
    output pmvw_pkg::t_cfg                o_cfg
);

    logic [pmvw_pkg::CFGD_W-1:0] r_cols;
    logic [pmvw_pkg::CFGD_W-1:0] r_rows;
    logic [pmvw_pkg::RAD_W-1:0]  r_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= pmvw_pkg::CFGD_W'(64);
            r_rows <= pmvw_pkg::CFGD_W'(64);
            r_rad  <= pmvw_pkg::RAD_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pmvw_pkg::CFG_GRID_COLS:     r_cols <= i_cfg_data;
                pmvw_pkg::CFG_GRID_ROWS:     r_rows <= i_cfg_data;
                pmvw_pkg::CFG_WINDOW_RADIUS: r_rad  <= i_cfg_data[pmvw_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize acts as the store size
    always_comb begin
        int c;
        int r;
        c = int'(r_cols);
        r = int'(r_rows);
        if (c == 0) c = 1;
        if (c > pmvw_pkg::MAX_COLS) c = pmvw_pkg::MAX_COLS;
        if (r == 0) r = 1;
        if (r > pmvw_pkg::MAX_ROWS) r = pmvw_pkg::MAX_ROWS;
        o_cfg.cols   = pmvw_pkg::DIM_W'(c);
        o_cfg.rows   = pmvw_pkg::DIM_W'(r);
        o_cfg.radius = r_rad;
    end

endmodule

// ----- design/pmvw_front.sv -----
// ----------------------------------------------------------------------------
// pmvw_front
// accepts write and query requests into a short queue for the back end
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmvw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pmvw_in_if.sink            i_in,
    input  logic               i_pop,
    output pmvw_pkg::t_q_head  o_head
);

    pmvw_pkg::t_item             r_q [0:pmvw_pkg::QDEPTH-1];
    logic [pmvw_pkg::QP_W-1:0]   r_wp;
    logic [pmvw_pkg::QP_W-1:0]   r_rp;
    logic [pmvw_pkg::QC_W-1:0]   r_cnt;
    logic                        push;
    logic                        pop;
    pmvw_pkg::t_item             in_item;

    assign i_in.ready = (r_cnt < pmvw_pkg::QC_W'(pmvw_pkg::QDEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && (r_cnt != '0);

    always_comb begin
        in_item.action = i_in.action;
        in_item.col    = i_in.col;
        in_item.row    = i_in.row;
        in_item.vec_x  = i_in.vec_x;
        in_item.vec_y  = i_in.vec_y;
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == pmvw_pkg::QP_W'(pmvw_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == pmvw_pkg::QP_W'(pmvw_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `ASSERT_NEXT(a_cnt_push, push && !pop, r_cnt == pmvw_pkg::QC_W'($past(r_cnt) + 1'b1), "queue count lost a push")
    `ASSERT_NEXT(a_cnt_pop, pop && !push, r_cnt == pmvw_pkg::QC_W'($past(r_cnt) - 1'b1), "queue count lost a pop")

endmodule

// ----- design/pmvw_back.sv -----
// ----------------------------------------------------------------------------
// pmvw_back
// vector store, window walker, histogram pipeline and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmvw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pmvw_pkg::t_cfg     i_cfg,
    input  pmvw_pkg::t_q_head  i_head,
    output logic               o_pop,
    pmvw_out_if.source         o_out
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0] r_state;

    logic [31:0]                      r_store [0:(pmvw_pkg::MAX_COLS * pmvw_pkg::MAX_ROWS)-1];
    logic [31:0]                      r_word;
    logic [pmvw_pkg::HCNT_W-1:0]      r_hx_mem [0:pmvw_pkg::HIST_BINS-1];
    logic [pmvw_pkg::HCNT_W-1:0]      r_hy_mem [0:pmvw_pkg::HIST_BINS-1];
    logic [pmvw_pkg::HCNT_W-1:0]      r_hqx;
    logic [pmvw_pkg::HCNT_W-1:0]      r_hqy;
    logic [pmvw_pkg::HIST_BINS-1:0]   r_hvx;
    logic [pmvw_pkg::HIST_BINS-1:0]   r_hvy;

    logic [pmvw_pkg::COL_W-1:0]       r_cx;
    logic [pmvw_pkg::ROW_W-1:0]       r_cy;
    logic signed [pmvw_pkg::OFS_W-1:0] r_ox;
    logic signed [pmvw_pkg::OFS_W-1:0] r_oy;

    logic                             r_s1_v;
    logic                             r_s2_v;
    logic [pmvw_pkg::BIN_W-1:0]       r_s2_bx;
    logic [pmvw_pkg::BIN_W-1:0]       r_s2_by;
    logic                             r_last_v;
    logic [pmvw_pkg::BIN_W-1:0]       r_last_bx;
    logic [pmvw_pkg::BIN_W-1:0]       r_last_by;
    logic [pmvw_pkg::HCNT_W-1:0]      r_last_cx;
    logic [pmvw_pkg::HCNT_W-1:0]      r_last_cy;

    logic [pmvw_pkg::HCNT_W-1:0]      r_pkx;
    logic [pmvw_pkg::HCNT_W-1:0]      r_pky;
    logic [pmvw_pkg::BIN_W-1:0]       r_pbx;
    logic [pmvw_pkg::BIN_W-1:0]       r_pby;

    logic                             r_out_v;
    logic signed [pmvw_pkg::OUT_W-1:0] r_out_x;
    logic signed [pmvw_pkg::OUT_W-1:0] r_out_y;
    logic                             r_out_f;

    logic [pmvw_pkg::ADDR_W-1:0]      rd_addr;
    logic [pmvw_pkg::ADDR_W-1:0]      wr_addr;
    logic                             wr_ok;
    logic                             store_we;
    logic                             take_write;
    logic                             take_query;
    logic                             out_free;
    logic                             walk_last;
    logic signed [pmvw_pkg::OFS_W-1:0] rad_pos;
    logic signed [pmvw_pkg::OFS_W-1:0] rad_neg;
    logic [pmvw_pkg::BIN_W-1:0]       s1_bx;
    logic [pmvw_pkg::BIN_W-1:0]       s1_by;
    logic [pmvw_pkg::HCNT_W-1:0]      cur_x;
    logic [pmvw_pkg::HCNT_W-1:0]      cur_y;
    logic [pmvw_pkg::HCNT_W-1:0]      n_cx;
    logic [pmvw_pkg::HCNT_W-1:0]      n_cy;
    logic                             res_found;

    assign rad_pos   = pmvw_pkg::OFS_W'({1'b0, i_cfg.radius});
    assign rad_neg   = pmvw_pkg::OFS_W'(0) - rad_pos;
    assign walk_last = (r_ox == rad_pos) && (r_oy == rad_pos);
    assign out_free  = !r_out_v || o_out.ready;

    assign take_write = (r_state == ST_IDLE) && i_head.valid
                        && (i_head.item.action == pmvw_pkg::ACT_WRITE);
    assign take_query = (r_state == ST_IDLE) && i_head.valid
                        && (i_head.item.action == pmvw_pkg::ACT_QUERY);
    assign o_pop      = take_write || ((r_state == ST_RESULT) && out_free);

    assign wr_ok    = (int'(i_head.item.col) < pmvw_pkg::MAX_COLS)
                      && (int'(i_head.item.row) < pmvw_pkg::MAX_ROWS);
    assign wr_addr  = pmvw_pkg::ADDR_W'(int'(i_head.item.row) * pmvw_pkg::MAX_COLS
                                        + int'(i_head.item.col));
    assign store_we = take_write && wr_ok;

    // window coordinate clamped to the grid edges
    always_comb begin
        int xx;
        int yy;
        xx = int'(r_cx) + int'(r_ox);
        yy = int'(r_cy) + int'(r_oy);
        if (xx > int'(i_cfg.cols) - 1) xx = int'(i_cfg.cols) - 1;
        if (xx < 0) xx = 0;
        if (yy > int'(i_cfg.rows) - 1) yy = int'(i_cfg.rows) - 1;
        if (yy < 0) yy = 0;
        rd_addr = pmvw_pkg::ADDR_W'(yy * pmvw_pkg::MAX_COLS + xx);
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[wr_addr] <= {i_head.item.vec_y, i_head.item.vec_x};
        end
        r_word <= r_store[rd_addr];
    end

    assign s1_bx = pmvw_pkg::to_bin(r_word[pmvw_pkg::VEC_W-1:0]);
    assign s1_by = pmvw_pkg::to_bin(r_word[2*pmvw_pkg::VEC_W-1:pmvw_pkg::VEC_W]);

    // the bin written last cycle is not yet visible in the read data
    always_comb begin
        if (r_last_v && (r_last_bx == r_s2_bx)) begin
            cur_x = r_last_cx;
        end else begin
            cur_x = r_hvx[r_s2_bx] ? r_hqx : '0;
        end
        if (r_last_v && (r_last_by == r_s2_by)) begin
            cur_y = r_last_cy;
        end else begin
            cur_y = r_hvy[r_s2_by] ? r_hqy : '0;
        end
        n_cx = cur_x + 1'b1;
        n_cy = cur_y + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_hx_mem[r_s2_bx] <= n_cx;
            r_hy_mem[r_s2_by] <= n_cy;
        end
        r_hqx <= r_hx_mem[s1_bx];
        r_hqy <= r_hy_mem[s1_by];
    end

    assign res_found = (r_pkx > pmvw_pkg::HCNT_W'(pmvw_pkg::PEAK_MIN))
                       || (r_pky > pmvw_pkg::HCNT_W'(pmvw_pkg::PEAK_MIN));

    // payload registers
    always_ff @(posedge i_clk) begin
        r_s2_bx <= s1_bx;
        r_s2_by <= s1_by;
        if (r_s2_v) begin
            r_last_bx <= r_s2_bx;
            r_last_by <= r_s2_by;
            r_last_cx <= n_cx;
            r_last_cy <= n_cy;
        end
        if (take_query) begin
            r_cx <= i_head.item.col;
            r_cy <= i_head.item.row;
        end
        if ((r_state == ST_RESULT) && out_free) begin
            r_out_f <= res_found;
            r_out_x <= res_found ? pmvw_pkg::OUT_W'({r_pbx, 1'b0}) - pmvw_pkg::OUT_W'(pmvw_pkg::PIX_MAX)
                                 : '0;
            r_out_y <= res_found ? pmvw_pkg::OUT_W'({r_pby, 1'b0}) - pmvw_pkg::OUT_W'(pmvw_pkg::PIX_MAX)
                                 : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_last_v <= 1'b0;
            r_hvx    <= '0;
            r_hvy    <= '0;
            r_pkx    <= '0;
            r_pky    <= '0;
            r_pbx    <= '0;
            r_pby    <= '0;
            r_ox     <= '0;
            r_oy     <= '0;
            r_out_v  <= 1'b0;
        end else begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= r_s1_v && (r_word != '0);
            r_last_v <= r_s2_v;

            if (r_s2_v) begin
                r_hvx[r_s2_bx] <= 1'b1;
                r_hvy[r_s2_by] <= 1'b1;
                if (n_cx > r_pkx) begin
                    r_pkx <= n_cx;
                    r_pbx <= r_s2_bx;
                end
                if (n_cy > r_pky) begin
                    r_pky <= n_cy;
                    r_pby <= r_s2_by;
                end
            end

            if (o_out.valid && o_out.ready) begin
                r_out_v <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (take_query) begin
                        r_ox     <= rad_neg;
                        r_oy     <= rad_neg;
                        r_hvx    <= '0;
                        r_hvy    <= '0;
                        r_pkx    <= '0;
                        r_pky    <= '0;
                        r_pbx    <= '0;
                        r_pby    <= '0;
                        r_last_v <= 1'b0;
                        r_state  <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    r_s1_v <= 1'b1;
                    if (r_ox == rad_pos) begin
                        r_ox <= rad_neg;
                        r_oy <= r_oy + 1'b1;
                    end else begin
                        r_ox <= r_ox + 1'b1;
                    end
                    if (walk_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_s1_v && !r_s2_v) begin
                        r_state <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (out_free) begin
                        r_out_v <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid     = r_out_v;
    assign o_out.popular_x = r_out_x;
    assign o_out.popular_y = r_out_y;
    assign o_out.found     = r_out_f;

    `ASSERT_IMPL(a_s2_from_s1, r_s2_v, $past(r_s1_v), "histogram stage fired without a store read")
    `ASSERT_IMPL(a_result_drained, r_state == ST_RESULT, !r_s1_v && !r_s2_v, "result before pipeline drained")
    `ASSERT_NEXT(a_result_loaded, (r_state == ST_RESULT) && o_pop, r_out_v, "query popped without a result")

endmodule

// ----- design/popular_motion_vector_window.sv -----
// ----------------------------------------------------------------------------
// popular_motion_vector_window
// mode filter over a clamped window of stored block motion vectors
//
//   channel   dir   handshake        payload
//   i_in      in    valid / ready    action, col, row, vec_x, vec_y
//   o_out     out   valid / ready    popular_x, popular_y, found
//   i_cfg_*   in    write enable     index, data (grid_cols, grid_rows, radius)
//
// a write request is stored and popped as soon as the idle back end takes it
// a query reads the (2*radius+1)^2 window cells, one store read per cell
//   through the single read port, then drains the pipeline and registers
//   the result
// requests queue two deep while the back end works or the result waits
// reset clears control only; store entries read as undefined until written
// ----------------------------------------------------------------------------
module popular_motion_vector_window (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pmvw_in_if.sink                      i_in,
    pmvw_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic [pmvw_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [pmvw_pkg::CFGD_W-1:0]  i_cfg_data
);

    pmvw_pkg::t_cfg    cfg;
    pmvw_pkg::t_q_head head;
    logic              pop;

    pmvw_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pmvw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (pop),
        .o_head  (head)
    );

    pmvw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
